// File: hw/rtl/rsi_pkg.sv
// Package for the rotary sector indexer: fixed field widths, register map
// constants and the shared result type. No dependencies.
package rsi_pkg;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index taken from the word address bit.
  localparam logic REG_HALF_PERIOD = 1'b0;

  // Half period register.
  localparam int            HALF_W          = 10;
  localparam logic [9:0]    HALF_PERIOD_RST = 10'd10;

  // Fixed field widths of the item payloads.
  localparam int SECTOR_FIELD_W = 4;
  localparam int TURNS_FIELD_W  = 4;

  // Request codes carried in req_type.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  // One result item.
  typedef struct packed {
    logic                             step_pin;
    logic                             dir_pin;
    logic                             ms1_pin;
    logic                             ms2_pin;
    logic                             enable_n_pin;
    logic                             busy_res;
    logic [SECTOR_FIELD_W-1:0]        sector_now;
    logic signed [TURNS_FIELD_W-1:0]  move_turns;
    logic                             rejected;
  } rsi_result_t;

endpackage

// File: hw/rtl/rsi_if.sv
// Valid/ready channel interfaces for the rotary sector indexer: the request
// channel and the result channel. Depends on rsi_pkg for field widths.
interface rsi_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [rsi_pkg::SECTOR_FIELD_W-1:0] target_sector;

  modport source (output valid, req_type, target_sector, input ready);
  modport sink   (input valid, req_type, target_sector, output ready);
endinterface

interface rsi_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     step_pin;
  logic                                     dir_pin;
  logic                                     ms1_pin;
  logic                                     ms2_pin;
  logic                                     enable_n_pin;
  logic                                     busy_res;
  logic [rsi_pkg::SECTOR_FIELD_W-1:0]       sector_now;
  logic signed [rsi_pkg::TURNS_FIELD_W-1:0] move_turns;
  logic                                     rejected;

  modport source (output valid, step_pin, dir_pin, ms1_pin, ms2_pin, enable_n_pin,
                  busy_res, sector_now, move_turns, rejected, input ready);
  modport sink   (input valid, step_pin, dir_pin, ms1_pin, ms2_pin, enable_n_pin,
                  busy_res, sector_now, move_turns, rejected, output ready);
endinterface

// File: hw/rtl/rsi_engine.sv
// Motion engine of the rotary sector indexer: shortest-path move planning,
// step pulse timing and the sector state. Depends on rsi_pkg.
module rsi_engine #(
  parameter int NUM_SECTORS    = 8,
  parameter int STEPS_PER_TURN = 800
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              proc,
  input  logic                              req_type,
  input  logic [rsi_pkg::SECTOR_FIELD_W-1:0] target_sector,
  input  logic [rsi_pkg::HALF_W-1:0]        half_period,
  output rsi_pkg::rsi_result_t              result
);
  import rsi_pkg::*;

  localparam int SECT_W          = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
  localparam int STEPS_PER_SECT  = STEPS_PER_TURN / NUM_SECTORS;
  localparam int MAX_STEPS       = (NUM_SECTORS / 2) * STEPS_PER_SECT;
  localparam int STEPS_W         = $clog2(MAX_STEPS + 2);

  logic [SECT_W-1:0]  sector_r,   sector_nxt;
  logic [SECT_W-1:0]  target_r,   target_nxt;
  logic [STEPS_W-1:0] steps_r,    steps_nxt;
  logic [HALF_W-1:0]  count_r,    count_nxt;
  logic               level_r,    level_nxt;
  logic               ccw_r,      ccw_nxt;
  logic               moving_r,   moving_nxt;

  logic [HALF_W-1:0]  limit;
  logic [HALF_W-1:0]  count_tmp;
  logic               tgt_ok;
  logic [SECT_W-1:0]  tgt_idx;
  logic [31:0]        cw_raw;
  logic [31:0]        cw;
  logic [31:0]        ccw;
  logic               go_ccw;
  logic [31:0]        mag;
  logic [STEPS_W-1:0] move_steps;
  logic [31:0]        turns_wide;
  logic [31:0]        sector_one;
  logic               rej;
  logic               accept_move;

  // A zero half period behaves as one tick.
  assign limit = (half_period == '0) ? HALF_W'(1) : half_period;

  // Move planning: clockwise distance by one compare and subtract, then the
  // counterclockwise complement; a tie goes clockwise.
  assign tgt_ok     = (target_sector != '0) && (32'(target_sector) <= 32'(NUM_SECTORS));
  assign tgt_idx    = SECT_W'(32'(target_sector) - 32'd1);
  assign cw_raw     = 32'(tgt_idx) + 32'(NUM_SECTORS) - 32'(sector_r);
  assign cw         = (cw_raw >= 32'(NUM_SECTORS)) ? cw_raw - 32'(NUM_SECTORS) : cw_raw;
  assign ccw        = (cw == 32'd0) ? 32'd0 : 32'(NUM_SECTORS) - cw;
  assign go_ccw     = cw > ccw;
  assign mag        = go_ccw ? ccw : cw;
  assign move_steps = STEPS_W'(mag * 32'(STEPS_PER_SECT));

  assign rej         = (req_type == REQ_MOVE) && (moving_r || !tgt_ok);
  assign accept_move = (req_type == REQ_MOVE) && !moving_r && tgt_ok;
  assign turns_wide  = accept_move ? (go_ccw ? 32'd0 - mag : mag) : 32'd0;

  // Next state for one item.
  always_comb begin
    sector_nxt = sector_r;
    target_nxt = target_r;
    steps_nxt  = steps_r;
    count_nxt  = count_r;
    level_nxt  = level_r;
    ccw_nxt    = ccw_r;
    moving_nxt = moving_r;
    count_tmp  = count_r;
    if (accept_move) begin
      target_nxt = tgt_idx;
      if (move_steps == '0) begin
        sector_nxt = tgt_idx;
        ccw_nxt    = 1'b0;
      end else begin
        ccw_nxt    = go_ccw;
        moving_nxt = 1'b1;
        steps_nxt  = move_steps;
        level_nxt  = 1'b1;
        count_nxt  = HALF_W'(1);
      end
    end else if ((req_type == REQ_TICK) && moving_r) begin
      if (count_r >= limit) begin
        count_tmp = '0;
        if (level_r) begin
          level_nxt = 1'b0;
        end else begin
          steps_nxt = steps_r - STEPS_W'(1);
          if (steps_r == STEPS_W'(1)) begin
            moving_nxt = 1'b0;
            ccw_nxt    = 1'b0;
            sector_nxt = target_r;
          end else begin
            level_nxt = 1'b1;
          end
        end
      end
      count_nxt = count_tmp + HALF_W'(1);
    end
  end

  // State registers advance only when an item is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_r <= '0;
      target_r <= '0;
      steps_r  <= '0;
      count_r  <= '0;
      level_r  <= 1'b0;
      ccw_r    <= 1'b0;
      moving_r <= 1'b0;
    end else if (proc) begin
      sector_r <= sector_nxt;
      target_r <= target_nxt;
      steps_r  <= steps_nxt;
      count_r  <= count_nxt;
      level_r  <= level_nxt;
      ccw_r    <= ccw_nxt;
      moving_r <= moving_nxt;
    end
  end

  // Result fields reflect the state after this item.
  assign sector_one = 32'(sector_nxt) + 32'd1;

  always_comb begin
    result.step_pin     = moving_nxt & level_nxt;
    result.dir_pin      = moving_nxt & ccw_nxt;
    result.ms1_pin      = 1'b0;
    result.ms2_pin      = moving_nxt;
    result.enable_n_pin = !moving_nxt;
    result.busy_res     = moving_nxt;
    result.sector_now   = sector_one[SECTOR_FIELD_W-1:0];
    result.move_turns   = turns_wide[TURNS_FIELD_W-1:0];
    result.rejected     = rej;
  end

endmodule

// File: hw/rtl/rotary_sector_indexer_top.sv
// Rotary sector indexer top level: item pipeline, APB register and outputs.
// One item per cycle sustained while the result channel takes results; an item
// passes the input register, then the result register. Reset is synchronous
// active low; it empties both registers, homes the carousel to sector one,
// stops any move and sets the half period to ten ticks.
// Depends on rsi_pkg, rsi_if and rsi_engine.
module rotary_sector_indexer_top #(
  parameter int NUM_SECTORS    = 8,
  parameter int STEPS_PER_TURN = 800
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rsi_in_if.sink                          in_chan,
  rsi_out_if.source                       out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rsi_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import rsi_pkg::*;

  logic               rd_sel;
  logic [HALF_W-1:0]  half_period_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_req_r;
  logic [SECTOR_FIELD_W-1:0] s1_tgt_r;
  logic               out_valid_r, out_valid_nxt;
  rsi_result_t        out_r;
  rsi_result_t        eng_result;
  logic               advance;
  logic               proc;
  logic               in_take;

  // Configuration register; the register index is the word address bit.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[CFG_ADDR_W-1] == REG_HALF_PERIOD)) begin
      half_period_r <= cfg_pwdata[HALF_W-1:0];
    end
  end

  assign rd_sel     = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_prdata = (rd_sel == REG_HALF_PERIOD) ? CFG_DATA_W'(half_period_r) : '0;

  // Handshake: the result register frees when empty or being taken.
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign proc          = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_chan.req_type;
      s1_tgt_r <= in_chan.target_sector;
    end
  end

  rsi_engine #(
    .NUM_SECTORS    (NUM_SECTORS),
    .STEPS_PER_TURN (STEPS_PER_TURN)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .proc          (proc),
    .req_type      (s1_req_r),
    .target_sector (s1_tgt_r),
    .half_period   (half_period_r),
    .result        (eng_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_r <= eng_result;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.step_pin     = out_r.step_pin;
  assign out_chan.dir_pin      = out_r.dir_pin;
  assign out_chan.ms1_pin      = out_r.ms1_pin;
  assign out_chan.ms2_pin      = out_r.ms2_pin;
  assign out_chan.enable_n_pin = out_r.enable_n_pin;
  assign out_chan.busy_res     = out_r.busy_res;
  assign out_chan.sector_now   = out_r.sector_now;
  assign out_chan.move_turns   = out_r.move_turns;
  assign out_chan.rejected     = out_r.rejected;

endmodule

// File: dv/rotary_sector_indexer_top_tb.sv
`timescale 1ns / 100ps
// Testbench for rotary_sector_indexer_top: directed table, then random phases per
// half-period setting, checked against an in-bench model. Needs rsi_pkg, rsi_if, RTL.
module rotary_sector_indexer_top_tb;
  import rsi_pkg::*;

  localparam int NUM_SECTORS    = 8;
  localparam int STEPS_PER_TURN = 800;
  localparam int CLK_HALF       = 5;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int IDLE_PERCENT   = 22;
  localparam int HOLD_CYCLES    = 250;
  localparam int HOLD_AT_RESULT = 700;
  localparam int NUM_PHASES     = 6;

  // Register addresses: the half period and an unused word next to it.
  localparam logic [CFG_ADDR_W-1:0] HALF_PERIOD_ADDR = {REG_HALF_PERIOD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_REG_ADDR   = {~REG_HALF_PERIOD, 2'b00};

  // Random phases: half period setting, item count, and whether idling is off.
  localparam int PHASE_TICKS [NUM_PHASES] = '{1, 0, 2, 1023, 1, 3};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{500, 300, 250, 150, 200, 150};
  localparam bit PHASE_QUIET [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

  typedef struct {
    logic        req;
    logic [3:0]  tgt;
    bit          typed;
    rsi_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rsi_in_if  in_if ();
  rsi_out_if out_if ();

  rotary_sector_indexer_top #(
    .NUM_SECTORS   (NUM_SECTORS),
    .STEPS_PER_TURN(STEPS_PER_TURN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Model state of the carousel and its step generator.
  logic [2:0]  carousel_idx;
  logic [2:0]  goal_idx;
  int          pulses_left;
  int          half_count;
  bit          step_high;
  bit          turning_ccw;
  bit          in_motion;
  logic [9:0]  half_period_reg;

  rsi_result_t pending_results[$];
  stim_row_t   plan[$];
  int          errors;
  int          mismatches;
  int          results_seen;
  int          cycles;
  bit          send_idle_on;
  bit          recv_idle_on;
  bit          hold_done;
  int          hold_left;

  // Pin pattern for a typed expectation: moving sets ms2 and clears enable_n.
  function automatic rsi_result_t pins(bit step, bit dir, bit busy, int sector, int turns,
                                       bit rej);
    rsi_result_t r;
    r.step_pin     = step;
    r.dir_pin      = dir;
    r.ms1_pin      = 1'b0;
    r.ms2_pin      = busy;
    r.enable_n_pin = ~busy;
    r.busy_res     = busy;
    r.sector_now   = 4'(sector);
    r.move_turns   = 4'(turns);
    r.rejected     = rej;
    return r;
  endfunction

  function automatic void add_row(logic req, logic [3:0] tgt, bit typed, rsi_result_t want);
    stim_row_t row;
    row.req   = req;
    row.tgt   = tgt;
    row.typed = typed;
    row.want  = want;
    plan.insert(plan.size(), row);
  endfunction

  // Advance the carousel model by one item and return the pins it shows.
  function automatic rsi_result_t step_carousel(logic req, logic [3:0] tgt);
    rsi_result_t      r;
    logic signed [3:0] turns;
    bit               rej;
    int               lim;
    int               goal;
    int               cw;
    int               ccw;
    int               mag;
    int               steps;
    turns = '0;
    rej   = 1'b0;
    lim   = (half_period_reg == 10'd0) ? 1 : int'(half_period_reg);
    if (req == REQ_MOVE) begin
      if (in_motion || tgt < 1 || int'(tgt) > NUM_SECTORS) begin
        rej = 1'b1;
      end else begin
        goal = int'(tgt) - 1;
        cw   = (goal + NUM_SECTORS - int'(carousel_idx)) % NUM_SECTORS;
        ccw  = (NUM_SECTORS - cw) % NUM_SECTORS;
        // A tie between the two ways round goes clockwise.
        if (cw <= ccw) begin
          turns       = 4'(cw);
          mag         = cw;
          turning_ccw = 1'b0;
        end else begin
          turns       = 4'(-ccw);
          mag         = ccw;
          turning_ccw = 1'b1;
        end
        steps    = mag * (STEPS_PER_TURN / NUM_SECTORS);
        goal_idx = 3'(goal);
        if (steps == 0) begin
          carousel_idx = 3'(goal);
          turning_ccw  = 1'b0;
        end else begin
          in_motion   = 1'b1;
          pulses_left = steps;
          step_high   = 1'b1;
          half_count  = 1;
        end
      end
    end else if (in_motion) begin
      // A tick ends the current half once the count reaches the half period.
      if (half_count >= lim) begin
        half_count = 0;
        if (step_high) begin
          step_high = 1'b0;
        end else begin
          pulses_left--;
          if (pulses_left == 0) begin
            in_motion    = 1'b0;
            turning_ccw  = 1'b0;
            carousel_idx = goal_idx;
          end else begin
            step_high = 1'b1;
          end
        end
      end
      half_count++;
    end
    r.step_pin     = in_motion & step_high;
    r.dir_pin      = in_motion & turning_ccw;
    r.ms1_pin      = 1'b0;
    r.ms2_pin      = in_motion;
    r.enable_n_pin = ~in_motion;
    r.busy_res     = in_motion;
    r.sector_now   = 4'(carousel_idx) + 4'd1;
    r.move_turns   = turns;
    r.rejected     = rej;
    return r;
  endfunction

  // Offer one item, wait for it to be taken, then record what it should produce.
  task automatic push_request(logic req, logic [3:0] tgt, bit typed, rsi_result_t want);
    rsi_result_t guess;
    while (send_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.req_type      = req;
    in_if.target_sector = tgt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    guess = step_carousel(req, tgt);
    if (typed) guess = want;
    pending_results.insert(pending_results.size(), guess);
    @(negedge clk);
  endtask

  // Random item: mostly ticks; moves are rare while moving and mostly to a neighbouring sector while idle.
  task automatic push_random_request();
    logic [3:0] tgt;
    logic       req;
    int         pick;
    tgt  = 4'($urandom_range(0, 15));
    req  = REQ_TICK;
    pick = $urandom_range(0, 99);
    if (in_motion) begin
      if (pick < 4) req = REQ_MOVE;
    end else if (pick < 45) begin
      req  = REQ_MOVE;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        tgt = 4'((int'(carousel_idx) + 1) % NUM_SECTORS + 1);
      end else if (pick < 70) begin
        tgt = 4'((int'(carousel_idx) + NUM_SECTORS - 1) % NUM_SECTORS + 1);
      end else if (pick < 85) begin
        tgt = 4'($urandom_range(1, NUM_SECTORS));
      end else begin
        pick = $urandom_range(NUM_SECTORS, 15);
        tgt  = (pick == NUM_SECTORS) ? 4'd0 : 4'(pick);
      end
    end
    push_request(req, tgt, 1'b0, '0);
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Read the half period back and compare with the model copy.
  task automatic check_half_period();
    logic [CFG_DATA_W-1:0] got;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = HALF_PERIOD_ADDR;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (got[HALF_W-1:0] !== half_period_reg) begin
      if (mismatches < 10)
        $display("half period readback: expected %0d, got %0d", half_period_reg,
                 got[HALF_W-1:0]);
      mismatches++;
      errors++;
    end
  endtask

  // Stop feeding and wait until every expected item has come back.
  task automatic drain();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the block.
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_if.ready = 1'b0;
      end else if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (recv_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Compare every taken result item with the oldest expectation.
  always @(posedge clk) begin
    rsi_result_t got;
    rsi_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.step_pin     = out_if.step_pin;
      got.dir_pin      = out_if.dir_pin;
      got.ms1_pin      = out_if.ms1_pin;
      got.ms2_pin      = out_if.ms2_pin;
      got.enable_n_pin = out_if.enable_n_pin;
      got.busy_res     = out_if.busy_res;
      got.sector_now   = out_if.sector_now;
      got.move_turns   = out_if.move_turns;
      got.rejected     = out_if.rejected;
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result item %p", got);
        mismatches++;
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("result %0d mismatch: expected %p, got %p", results_seen, want, got);
          mismatches++;
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotary_sector_indexer_top test failed");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.req_type      = REQ_TICK;
    in_if.target_sector = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    errors              = 0;
    mismatches          = 0;
    results_seen        = 0;
    cycles              = 0;
    send_idle_on        = 1'b1;
    recv_idle_on        = 1'b1;
    carousel_idx        = '0;
    goal_idx            = '0;
    pulses_left         = 0;
    half_count          = 0;
    step_high           = 1'b0;
    turning_ccw         = 1'b0;
    in_motion           = 1'b0;
    half_period_reg     = HALF_PERIOD_RST;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    check_half_period();

    // Directed rows, run with the reset half period of ten ticks.
    add_row(REQ_TICK, 4'd3,  1'b1, pins(0, 0, 0, 1, 0, 0));
    add_row(REQ_MOVE, 4'd0,  1'b1, pins(0, 0, 0, 1, 0, 1));
    add_row(REQ_MOVE, 4'd9,  1'b1, pins(0, 0, 0, 1, 0, 1));
    add_row(REQ_MOVE, 4'd15, 1'b1, pins(0, 0, 0, 1, 0, 1));
    // Request for the sector already in place: accepted, nothing moves.
    add_row(REQ_MOVE, 4'd1,  1'b1, pins(0, 0, 0, 1, 0, 0));
    add_row(REQ_TICK, 4'd0,  1'b1, pins(0, 0, 0, 1, 0, 0));
    // Half way round is a tie and turns clockwise by four sectors.
    add_row(REQ_MOVE, 4'd5,  1'b1, pins(1, 0, 1, 1, 4, 0));
    // Requests during the move are refused and the move carries on.
    add_row(REQ_MOVE, 4'd2,  1'b1, pins(1, 0, 1, 1, 0, 1));
    add_row(REQ_MOVE, 4'd8,  1'b1, pins(1, 0, 1, 1, 0, 1));
    add_row(REQ_MOVE, 4'd0,  1'b1, pins(1, 0, 1, 1, 0, 1));
    for (int i = 0; i < 12; i++) add_row(REQ_TICK, 4'(i), 1'b0, '0);
    add_row(REQ_MOVE, 4'd6,  1'b0, '0);
    foreach (plan[i]) push_request(plan[i].req, plan[i].tgt, plan[i].typed, plan[i].want);
    drain();

    // The unused register word must not disturb the half period.
    apb_write(SPARE_REG_ADDR, $urandom());
    check_half_period();

    // Random phases, one half period setting each, written while nothing is in flight.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apb_write(HALF_PERIOD_ADDR, {22'($urandom()), 10'(PHASE_TICKS[p])});
      half_period_reg = 10'(PHASE_TICKS[p]);
      check_half_period();
      send_idle_on = ~PHASE_QUIET[p];
      recv_idle_on = ~PHASE_QUIET[p];
      for (int n = 0; n < PHASE_ITEMS[p]; n++) push_random_request();
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("rotary_sector_indexer_top test passed");
    end else begin
      $display("rotary_sector_indexer_top test failed");
    end
    $finish;
  end

endmodule
